### rtl/ptw_pkg.sv
// Shared types and helpers of the four-level page table walker.
`default_nettype none
package ptw_pkg;

  localparam int unsigned VaWidth    = 48;
  localparam int unsigned PaWidth    = 52;
  localparam int unsigned EntryWidth = 64;
  localparam int unsigned FrameWidth = 40;
  localparam int unsigned IdxWidth   = 9;
  localparam int unsigned PageShift  = 12;
  localparam int unsigned PresentBit = 0;
  localparam int unsigned PsBit      = 7;

  typedef enum logic {
    OpStart    = 1'b0,
    OpResponse = 1'b1
  } op_e;

  typedef enum logic {
    KindRead   = 1'b0,
    KindFinish = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    Level1 = 2'd0,
    Level2 = 2'd1,
    Level3 = 2'd2,
    Level4 = 2'd3
  } level_e;

  // Classified transaction handed from the front to the back through the queue.
  typedef struct packed {
    logic                  is_start;
    logic                  fault;
    logic                  ps_set;
    logic [VaWidth-1:0]    virt_addr;
    logic [FrameWidth-1:0] table_base;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Nine-bit table index of a virtual address for a level.
  function automatic logic [IdxWidth-1:0] level_index(input logic [VaWidth-1:0] va,
                                                      input level_e lvl);
    logic [IdxWidth-1:0] idx;
    unique case (lvl)
      Level4:  idx = va[47:39];
      Level3:  idx = va[38:30];
      Level2:  idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage
`default_nettype wire

### rtl/ptw_if.sv
// Valid/ready channel interfaces for walker input and output transactions.
`default_nettype none
interface ptw_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic [ptw_pkg::VaWidth-1:0]        virt_addr;
  logic [ptw_pkg::PaWidth-1:0]        root_table;
  logic [ptw_pkg::EntryWidth-1:0]     entry_data;
  logic                               read_ok;

  modport source (output valid, operation, virt_addr, root_table, entry_data, read_ok,
                  input ready);
  modport sink (input valid, operation, virt_addr, root_table, entry_data, read_ok,
                output ready);
endinterface

interface ptw_out_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [ptw_pkg::PaWidth-1:0]        read_addr;
  logic [ptw_pkg::FrameWidth-1:0]     frame;
  logic                               fault;
  logic                               large_page;

  modport source (output valid, kind, read_addr, frame, fault, large_page, input ready);
  modport sink (input valid, kind, read_addr, frame, fault, large_page, output ready);
endinterface
`default_nettype wire

### rtl/ptw_front.sv
// Front end: accepts input transactions and classifies them for the queue.
`default_nettype none
module ptw_front (
  ptw_in_if.sink                 in_i,
  input  ptw_pkg::queue_status_t status_i,
  output logic                   push_o,
  output ptw_pkg::item_t         item_o
);

  logic is_start;

  assign is_start   = (in_i.operation == ptw_pkg::OpStart);
  assign in_i.ready = !status_i.full;
  assign push_o     = in_i.valid && !status_i.full;

  always_comb begin
    item_o.is_start  = is_start;
    item_o.fault     = !in_i.read_ok || !in_i.entry_data[ptw_pkg::PresentBit];
    item_o.ps_set    = in_i.entry_data[ptw_pkg::PsBit];
    item_o.virt_addr = in_i.virt_addr;
    // The table base drops the low 12 bits of either the root or the entry.
    if (is_start) begin
      item_o.table_base = in_i.root_table[ptw_pkg::PaWidth-1:ptw_pkg::PageShift];
    end else begin
      item_o.table_base = in_i.entry_data[ptw_pkg::PaWidth-1:ptw_pkg::PageShift];
    end
  end

endmodule
`default_nettype wire

### rtl/ptw_queue.sv
// Two-entry queue between the walker front end and back end.
`default_nettype none
module ptw_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ptw_pkg::item_t         item_i,
  input  logic                   pop_i,
  output ptw_pkg::item_t         head_o,
  output ptw_pkg::queue_status_t status_o
);

  ptw_pkg::item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

### rtl/ptw_back.sv
// Back end: walk state and registered result transactions.
`default_nettype none
module ptw_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ptw_pkg::queue_status_t status_i,
  input  ptw_pkg::item_t         head_i,
  output logic                   pop_o,
  ptw_out_if.source              out_o
);

  logic                                 walking_q, walking_d;
  ptw_pkg::level_e                      level_q, level_d;
  logic [ptw_pkg::VaWidth-1:0]          va_q, va_d;
  logic                                 valid_q, valid_d;
  ptw_pkg::kind_e                       kind_q, kind_d;
  logic [ptw_pkg::PaWidth-1:0]          addr_q, addr_d;
  logic [ptw_pkg::FrameWidth-1:0]       frame_q, frame_d;
  logic                                 fault_q, fault_d;
  logic                                 large_q, large_d;
  logic                                 take, emit;
  ptw_pkg::level_e                      next_level;

  assign take = !status_i.empty && (!valid_q || out_o.ready);
  assign pop_o = take;
  assign next_level = ptw_pkg::level_e'(level_q - 2'd1);

  always_comb begin
    walking_d = walking_q;
    level_d   = level_q;
    va_d      = va_q;
    emit      = 1'b0;
    kind_d    = ptw_pkg::KindRead;
    addr_d    = '0;
    frame_d   = '0;
    fault_d   = 1'b0;
    large_d   = 1'b0;
    if (take) begin
      if (head_i.is_start) begin
        if (!walking_q) begin
          walking_d = 1'b1;
          va_d      = head_i.virt_addr;
          level_d   = ptw_pkg::Level4;
          emit      = 1'b1;
          addr_d    = {head_i.table_base,
                       ptw_pkg::level_index(head_i.virt_addr, ptw_pkg::Level4), 3'b000};
        end
      end else if (walking_q) begin
        emit = 1'b1;
        priority if (head_i.fault) begin
          walking_d = 1'b0;
          kind_d    = ptw_pkg::KindFinish;
          fault_d   = 1'b1;
        end else if (level_q == ptw_pkg::Level2 && head_i.ps_set) begin
          walking_d = 1'b0;
          kind_d    = ptw_pkg::KindFinish;
          large_d   = 1'b1;
          frame_d   = {head_i.table_base[ptw_pkg::FrameWidth-1:9], va_q[20:12]};
        end else if (level_q == ptw_pkg::Level1) begin
          walking_d = 1'b0;
          kind_d    = ptw_pkg::KindFinish;
          frame_d   = head_i.table_base;
        end else begin
          level_d = next_level;
          addr_d  = {head_i.table_base, ptw_pkg::level_index(va_q, next_level), 3'b000};
        end
      end
    end
    valid_d = take ? emit : (valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walking_q <= 1'b0;
      level_q   <= ptw_pkg::Level1;
      va_q      <= '0;
      valid_q   <= 1'b0;
      kind_q    <= ptw_pkg::KindRead;
      addr_q    <= '0;
      frame_q   <= '0;
      fault_q   <= 1'b0;
      large_q   <= 1'b0;
    end else begin
      walking_q <= walking_d;
      level_q   <= level_d;
      va_q      <= va_d;
      valid_q   <= valid_d;
      if (take && emit) begin
        kind_q  <= kind_d;
        addr_q  <= addr_d;
        frame_q <= frame_d;
        fault_q <= fault_d;
        large_q <= large_d;
      end
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.kind       = kind_q;
  assign out_o.read_addr  = addr_q;
  assign out_o.frame      = frame_q;
  assign out_o.fault      = fault_q;
  assign out_o.large_page = large_q;

endmodule
`default_nettype wire

### rtl/four_level_page_table_walker_unit.sv
// Top level of the four-level page table walker.
//
// The walker takes transactions on in_i: a start (operation 0) carries the
// virtual address and root table address, a response (operation 1) carries
// the entry read from memory and its success flag. Each accepted start while
// idle, and each response while walking, yields exactly one transaction on
// out_o: either a read request for the next entry or a finished translation
// with frame, fault and large-page flags. Starts while walking and responses
// while idle are dropped without a result.
// The front end classifies each transaction and pushes it into a two-entry
// queue; the back end owns the walk state and a registered output stage.
// Throughput, while out_o.ready is high, is one transaction per cycle, set by the
// back end retiring one queue entry per cycle into the registered output stage.
// When the receiver holds out_o.ready low, the back end stops popping, the
// queue fills and in_i.ready drops once both entries are occupied.
// Reset (rst_ni low) empties the queue, drops any pending result and returns
// the walker to idle.
`default_nettype none
module four_level_page_table_walker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptw_in_if.sink     in_i,
  ptw_out_if.source  out_o
);

  ptw_pkg::queue_status_t status;
  ptw_pkg::item_t         push_item;
  ptw_pkg::item_t         head_item;
  logic                   push;
  logic                   pop;

  // Classification happens in the same cycle a transaction is accepted.
  ptw_front u_front (
    .in_i     (in_i),
    .status_i (status),
    .push_o   (push),
    .item_o   (push_item)
  );

  // The queue decouples acceptance from the walk so either side can stall.
  ptw_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .head_o   (head_item),
    .status_o (status)
  );

  // The back end advances the walk and registers at most one result per entry.
  ptw_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .head_i   (head_item),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
`default_nettype wire

### tb/four_level_page_table_walker_unit_test.sv
// Self-checking testbench of the four-level page table walker with a built-in walk predictor.
`timescale 1ns / 100ps
module four_level_page_table_walker_unit_test;
  import ptw_pkg::*;

  // One transaction leaving the walker: a read request or a finished translation.
  typedef struct packed {
    kind_e                 kind;
    logic [PaWidth-1:0]    read_addr;
    logic [FrameWidth-1:0] frame;
    logic                  fault;
    logic                  large_page;
  } walk_result_t;

  // The receiver holds off for this many cycles during the backpressure test.
  localparam int unsigned HoldCycles = 200;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int unsigned SettleCycles = 10;

  logic clk_i;
  logic rst_ni;

  ptw_in_if  in_ch ();
  ptw_out_if out_ch ();

  four_level_page_table_walker_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Shadow copy of the walk state, advanced once per accepted transaction.
  bit                 walk_active = 1'b0;
  level_e             walk_level = Level1;
  logic [PaWidth-1:0] walk_entry_addr = '0;
  logic [VaWidth-1:0] walk_va = '0;

  // Results predicted but not yet seen on the output channel, oldest first.
  walk_result_t walk_results_due[$];

  int unsigned results_predicted = 0;
  int unsigned mismatch_count = 0;

  // Idle and stall rates in percent per cycle, changed between test phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Set by a test to make the receiver hold ready low for a long stretch.
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Byte offset of the entry for a level: the 9-bit table index times 8.
  function automatic logic [PaWidth-1:0] entry_offset(input logic [VaWidth-1:0] va,
                                                      input level_e lvl);
    logic [VaWidth-1:0] shifted;
    logic [PaWidth-1:0] offset;
    shifted = va >> (PageShift + 9 * int'(lvl));
    offset = '0;
    offset[11:0] = {shifted[8:0], 3'b000};
    return offset;
  endfunction

  // Advances the shadow walk by one transaction. Returns 1 when the walker is
  // expected to produce a result for it, and that result in res.
  function automatic bit next_walk_result(input op_e op,
                                          input logic [VaWidth-1:0] va,
                                          input logic [PaWidth-1:0] root,
                                          input logic [EntryWidth-1:0] entry,
                                          input logic ok,
                                          output walk_result_t res);
    logic [PaWidth-1:0] table_addr;
    res = '0;
    if (op == OpStart) begin
      // A start during a walk is dropped without touching the walk.
      if (walk_active) return 1'b0;
      walk_active = 1'b1;
      walk_va = va;
      walk_level = Level4;
      table_addr = {root[PaWidth-1:PageShift], {PageShift{1'b0}}};
      walk_entry_addr = table_addr + entry_offset(va, Level4);
      res.kind = KindRead;
      res.read_addr = walk_entry_addr;
      return 1'b1;
    end
    // A response with no walk in progress is dropped as well.
    if (!walk_active) return 1'b0;
    res.kind = KindFinish;
    if (!ok || !entry[PresentBit]) begin
      walk_active = 1'b0;
      res.fault = 1'b1;
      return 1'b1;
    end
    // The page-size bit only means a 2 MiB page at level 2.
    if (walk_level == Level2 && entry[PsBit]) begin
      walk_active = 1'b0;
      res.frame = {entry[PaWidth-1:21], walk_va[20:PageShift]};
      res.large_page = 1'b1;
      return 1'b1;
    end
    if (walk_level == Level1) begin
      walk_active = 1'b0;
      res.frame = entry[PaWidth-1:PageShift];
      return 1'b1;
    end
    walk_level = level_e'(walk_level - 2'd1);
    table_addr = {entry[PaWidth-1:PageShift], {PageShift{1'b0}}};
    walk_entry_addr = table_addr + entry_offset(walk_va, walk_level);
    res.kind = KindRead;
    res.read_addr = walk_entry_addr;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offers one transaction until it is accepted, predicts its result and then
  // idles the sender for a random number of cycles at the current idle rate.
  // Always entered and left at a rising edge; unless the sender idled, valid stays
  // high on exit so that a back-to-back transaction can follow without a gap.
  task automatic send_item(input op_e op, input logic [VaWidth-1:0] va,
                           input logic [PaWidth-1:0] root,
                           input logic [EntryWidth-1:0] entry, input logic ok);
    walk_result_t res;
    in_ch.operation  <= op;
    in_ch.virt_addr  <= va;
    in_ch.root_table <= root;
    in_ch.entry_data <= entry;
    in_ch.read_ok    <= ok;
    in_ch.valid      <= 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    if (next_walk_result(op, va, root, entry, ok, res)) begin
      walk_results_due.push_back(res);
      results_predicted++;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Drops valid and waits until every predicted result has come out.
  // The queue is checked only after a rising edge, so the next valid does not land in this step.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (walk_results_due.size() != 0);
  endtask

  // One well-formed walk with random content: a start, then responses until
  // the shadow walk ends. Mostly present entries and successful reads, so most
  // walks reach level 1 or a large page, with an occasional stray start in the
  // middle and a stray response afterwards.
  task automatic run_random_walk();
    logic [63:0] r_va;
    logic [63:0] r_root;
    logic [63:0] r_entry;
    logic        ok;
    r_va   = {$urandom, $urandom};
    r_root = {$urandom, $urandom};
    case ($urandom_range(15))
      0:       r_va = '0;
      1:       r_va = '1;
      default: ;
    endcase
    send_item(OpStart, r_va[VaWidth-1:0], r_root[PaWidth-1:0], {$urandom, $urandom},
              1'($urandom_range(1)));
    while (walk_active) begin
      if ($urandom_range(99) < 4) begin
        // Start while busy: must be ignored.
        r_va   = {$urandom, $urandom};
        r_root = {$urandom, $urandom};
        send_item(OpStart, r_va[VaWidth-1:0], r_root[PaWidth-1:0], {$urandom, $urandom},
                  1'($urandom_range(1)));
      end else begin
        r_entry = {$urandom, $urandom};
        r_entry[PresentBit] = ($urandom_range(99) >= 6);
        ok = ($urandom_range(99) >= 4);
        r_va = {$urandom, $urandom};
        r_root = {$urandom, $urandom};
        send_item(OpResponse, r_va[VaWidth-1:0], r_root[PaWidth-1:0], r_entry, ok);
      end
    end
    if ($urandom_range(99) < 4) begin
      // Response while idle: must be ignored.
      r_va   = {$urandom, $urandom};
      r_root = {$urandom, $urandom};
      send_item(OpResponse, r_va[VaWidth-1:0], r_root[PaWidth-1:0], {$urandom, $urandom},
                1'($urandom_range(1)));
    end
  endtask

  // Extremes of every field: all-zero and all-one addresses and entries, and
  // the page-size bit at levels 4, 3 and 1 where it must not end the walk.
  task automatic test_field_extremes();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // Minimal walk down to level 1 with only the present bit set.
    send_item(OpStart, '0, '0, '0, 1'b0);
    repeat (4) send_item(OpResponse, '0, '0, 64'h1, 1'b1);
    // All ones: size bit ignored at levels 4 and 3, a large page at level 2.
    send_item(OpStart, '1, '1, '1, 1'b1);
    repeat (3) send_item(OpResponse, '1, '1, '1, 1'b1);
    // Size bit set at levels 4, 3 and 1 but clear at level 2: a 4 KiB frame.
    send_item(OpStart, '0, '1, '0, 1'b0);
    send_item(OpResponse, '0, '0, '1, 1'b1);
    send_item(OpResponse, '0, '0, '1, 1'b1);
    send_item(OpResponse, '0, '0, 64'hffff_ffff_ffff_ff7f, 1'b1);
    send_item(OpResponse, '0, '0, '1, 1'b1);
    wait_for_results();
  endtask

  // Faults: a failed read with an otherwise valid entry, and a clear present
  // bit deeper in the walk.
  task automatic test_faults();
    send_item(OpStart, 48'h1234_5678_9abc, 52'h1_2345_6789_a000, '0, 1'b1);
    send_item(OpResponse, '0, '0, '1, 1'b0);
    send_item(OpStart, 48'h8000_4020_1008, 52'hf_edcb_a987_6fff, '0, 1'b1);
    send_item(OpResponse, '0, '0, 64'h0000_000f_ffff_f001, 1'b1);
    send_item(OpResponse, '0, '0, 64'hffff_ffff_ffff_fffe, 1'b1);
    wait_for_results();
  endtask

  // A response while idle and a start while busy must both be dropped.
  task automatic test_ignored_items();
    send_item(OpResponse, '1, '1, '1, 1'b1);
    send_item(OpStart, 48'h0000_0020_0000, 52'h0_0000_0040_0000, '0, 1'b0);
    send_item(OpStart, '1, '1, '1, 1'b1);
    send_item(OpResponse, '0, '0, 64'h0000_0000_0000_0080, 1'b0);
    wait_for_results();
  endtask

  // Random walks at the given idle and stall rates until enough results came.
  task automatic test_random_walks(input int unsigned n_results, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    int unsigned start_count;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start_count = results_predicted;
    while (results_predicted - start_count < n_results) run_random_walk();
    wait_for_results();
  endtask

  // The receiver holds ready low for a long stretch while the sender keeps
  // offering back-to-back transactions, so the walker fills and stalls its input.
  task automatic test_output_backpressure();
    int unsigned start_count;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    start_count = results_predicted;
    hold_request = 1'b1;
    while (results_predicted - start_count < 60) run_random_walk();
    wait_for_results();
  endtask

  // The sender stops after each walk until every result of it has come out.
  task automatic test_pause_until_drained();
    send_idle_pct = 0;
    recv_stall_pct = 50;
    repeat (20) begin
      run_random_walk();
      wait_for_results();
    end
  endtask

  // Receiver side: random stalls, or a long hold-off counted here on request.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HoldCycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every accepted output transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin
    walk_result_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (walk_results_due.size() == 0) begin
        report_mismatch("result with nothing expected, kind", 64'(out_ch.kind), 64'h0);
      end else begin
        want = walk_results_due.pop_front();
        if (out_ch.kind !== want.kind)
          report_mismatch("kind", 64'(out_ch.kind), 64'(want.kind));
        if (out_ch.read_addr !== want.read_addr)
          report_mismatch("read_addr", 64'(out_ch.read_addr), 64'(want.read_addr));
        if (out_ch.frame !== want.frame)
          report_mismatch("frame", 64'(out_ch.frame), 64'(want.frame));
        if (out_ch.fault !== want.fault)
          report_mismatch("fault", 64'(out_ch.fault), 64'(want.fault));
        if (out_ch.large_page !== want.large_page)
          report_mismatch("large_page", 64'(out_ch.large_page), 64'(want.large_page));
      end
    end
  end

  // Generous upper bound on the run; a hang ends here.
  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OpStart;
    in_ch.virt_addr  = '0;
    in_ch.root_table = '0;
    in_ch.entry_data = '0;
    in_ch.read_ok    = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_faults();
    test_ignored_items();
    // Random phases: no idling, a mostly idle sender, a mostly stalling
    // receiver, and both idling now and then.
    test_random_walks(400, 0, 0);
    test_random_walks(350, 80, 0);
    test_random_walks(350, 0, 80);
    test_random_walks(350, 9, 9);
    test_output_backpressure();
    test_pause_until_drained();

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && walk_results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
